FILE: rtl/skt_pkg.sv
package skt_pkg;

	// Table geometry
	localparam int TableDepth = 64;
	localparam int IdxW       = $clog2(TableDepth);
	localparam int CntW       = $clog2(TableDepth + 1);

	// Field widths
	localparam int IdW    = 32;
	localparam int LenW   = 10;
	localparam int HashW  = 5;
	localparam int DelayW = 24;
	localparam int PosW   = 6;

	localparam logic [LenW-1:0] SecureLengthReset = LenW'(10);

	// Operation codes carried in s_tuser
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// One stored key descriptor, also the input payload layout (id in the low bits)
	typedef struct packed {
		logic [DelayW-1:0] delay;
		logic [HashW-1:0]  hash;
		logic [LenW-1:0]   len;
		logic              cls;
		logic [IdW-1:0]    id;
	} entry_t;

	// Result payload, found in bit 0
	typedef struct packed {
		logic              table_full;
		logic              duplicate;
		logic              secure_length;
		logic [DelayW-1:0] match_delay;
		logic [HashW-1:0]  found_hash;
		logic              found_class;
		logic [PosW-1:0]   position;
		logic              cache_hit;
		logic              found;
	} result_t;

	localparam int InW     = $bits(entry_t);
	localparam int InBytes = (InW + 7) / 8;
	localparam int OutW    = $bits(result_t);
	localparam int OutBytes = (OutW + 7) / 8;

	// Controller states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_START = 9'b000000010,
		ST_PROBE = 9'b000000100,
		ST_CMP   = 9'b000001000,
		ST_CREAD = 9'b000010000,
		ST_SHRD  = 9'b000100000,
		ST_SHWR  = 9'b001000000,
		ST_PUT   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

endpackage

FILE: rtl/sorted_key_table_with_lookup_cache.sv
// Sorted key-descriptor table with a last-hit lookup cache. One item is taken at a time
// through s_tvalid/s_tready; each item gives exactly one result transfer on m_*. All
// descriptors live in one single-port-write, registered-read memory; every binary-search
// probe is an address step (PROBE) and a compare on the registered read data (CMP), so
// timing is set by that memory port. Clear goes from START to DONE; a cache-answered lookup
// reads the cached slot (CREAD); a searched lookup probes to a match or an empty range; an
// insert into a full table probes and flags table_full; any other insert probes, moves each
// entry at or above the slot up one (SHRD, SHWR) and writes the key (PUT). A new item may be
// taken while the previous result still waits on m_tready. The user must write min_secure_length
// over cfg_valid/cfg_data only while the block is idle; the block does not enforce it.
module sorted_key_table_with_lookup_cache (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [skt_pkg::LenW-1:0]          cfg_data,      // min_secure_length
	// command stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [skt_pkg::InBytes*8-1:0]     s_tdata,       // key_id, key_class, key_len, hash_select, delay_ns
	input  logic [1:0]                        s_tuser,       // operation
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [skt_pkg::OutBytes*8-1:0]    m_tdata        // found, cache_hit, position, found_class, found_hash, match_delay, secure_length, duplicate, table_full
);

	// Descriptor memory
	skt_pkg::entry_t mem_q [skt_pkg::TableDepth];
	skt_pkg::entry_t rd_q;

	// Control and working registers
	skt_pkg::state_t             state_q;
	skt_pkg::op_t                op_q;
	skt_pkg::entry_t             key_q;
	logic [skt_pkg::CntW-1:0]    lo_q, hi_q, i_q, count_q;
	logic [skt_pkg::IdxW-1:0]    mid_q;
	logic                        dup_q;
	skt_pkg::result_t            res_q, out_q;
	logic                        out_valid_q;
	logic                        hit_valid_q;
	logic [skt_pkg::IdW-1:0]     hit_id_q;
	logic [skt_pkg::IdxW-1:0]    hit_pos_q;
	logic [skt_pkg::LenW-1:0]    min_len_q;

	// Memory port controls
	logic                        rd_en, wr_en;
	logic [skt_pkg::IdxW-1:0]    rd_addr, wr_addr;
	skt_pkg::entry_t             wr_data;

	logic [skt_pkg::CntW:0]      mid_sum;
	logic [skt_pkg::CntW-1:0]    mid_full, i_dec;
	logic [skt_pkg::IdxW-1:0]    mid_idx;
	logic                        range_open, cache_ok, out_free, secure;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == skt_pkg::ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(skt_pkg::OutBytes*8 - skt_pkg::OutW){1'b0}}, out_q};

	// Search midpoint of [lo, hi)
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_full   = mid_sum[skt_pkg::CntW:1];
	assign mid_idx    = mid_full[skt_pkg::IdxW-1:0];
	assign range_open = (lo_q < hi_q);
	assign i_dec      = i_q - skt_pkg::CntW'(1);
	assign cache_ok   = hit_valid_q && (hit_id_q == key_q.id) &&
	                    ({1'b0, hit_pos_q} < count_q);
	assign out_free   = !out_valid_q || m_tready;
	assign secure     = rd_q.cls || (rd_q.len >= min_len_q);

	// Memory access selection per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid_idx;
		wr_en   = 1'b0;
		wr_addr = lo_q[skt_pkg::IdxW-1:0];
		wr_data = key_q;
		case (state_q)
			skt_pkg::ST_START: begin
				if (op_q == skt_pkg::OP_LOOKUP && cache_ok) begin
					rd_en   = 1'b1;
					rd_addr = hit_pos_q;
				end
			end
			skt_pkg::ST_PROBE: begin
				rd_en = range_open;
			end
			skt_pkg::ST_SHRD: begin
				rd_en   = 1'b1;
				rd_addr = i_dec[skt_pkg::IdxW-1:0];
			end
			skt_pkg::ST_SHWR: begin
				wr_en   = 1'b1;
				wr_addr = i_q[skt_pkg::IdxW-1:0];
				wr_data = rd_q;
			end
			skt_pkg::ST_PUT: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Memory array with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= skt_pkg::SecureLengthReset;
		end else if (cfg_valid && cfg_ready) begin
			min_len_q <= cfg_data;
		end
	end

	// Command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skt_pkg::ST_IDLE;
			count_q     <= '0;
			hit_valid_q <= 1'b0;
			hit_id_q    <= '0;
			hit_pos_q   <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			mid_q       <= '0;
			dup_q       <= 1'b0;
		end else begin
			// result register: loaded from DONE, emptied by a result transfer
			if (state_q == skt_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				skt_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= skt_pkg::ST_START;
					end
				end
				skt_pkg::ST_START: begin
					res_q <= '0;
					lo_q  <= '0;
					hi_q  <= count_q;
					dup_q <= 1'b0;
					case (op_q)
						skt_pkg::OP_CLEAR: begin
							count_q     <= '0;
							hit_valid_q <= 1'b0;
							state_q     <= skt_pkg::ST_DONE;
						end
						skt_pkg::OP_INSERT: begin
							state_q <= skt_pkg::ST_PROBE;
						end
						skt_pkg::OP_LOOKUP: begin
							state_q <= cache_ok ? skt_pkg::ST_CREAD : skt_pkg::ST_PROBE;
						end
						default: begin
							state_q <= skt_pkg::ST_DONE;
						end
					endcase
				end
				skt_pkg::ST_CREAD: begin
					res_q.found         <= 1'b1;
					res_q.cache_hit     <= 1'b1;
					res_q.position      <= skt_pkg::PosW'(hit_pos_q);
					res_q.found_class   <= rd_q.cls;
					res_q.found_hash    <= rd_q.hash;
					res_q.match_delay   <= rd_q.delay;
					res_q.secure_length <= secure;
					state_q             <= skt_pkg::ST_DONE;
				end
				skt_pkg::ST_PROBE: begin
					mid_q <= mid_idx;
					if (range_open) begin
						state_q <= skt_pkg::ST_CMP;
					end else if (op_q == skt_pkg::OP_LOOKUP) begin
						// miss: result stays zero, cache kept
						state_q <= skt_pkg::ST_DONE;
					end else if (count_q >= skt_pkg::CntW'(skt_pkg::TableDepth)) begin
						res_q.duplicate  <= dup_q;
						res_q.table_full <= 1'b1;
						state_q          <= skt_pkg::ST_DONE;
					end else begin
						i_q     <= count_q;
						state_q <= (count_q > lo_q) ? skt_pkg::ST_SHRD : skt_pkg::ST_PUT;
					end
				end
				skt_pkg::ST_CMP: begin
					if (op_q == skt_pkg::OP_LOOKUP) begin
						if (key_q.id < rd_q.id) begin
							hi_q    <= skt_pkg::CntW'(mid_q);
							state_q <= skt_pkg::ST_PROBE;
						end else if (key_q.id > rd_q.id) begin
							lo_q    <= skt_pkg::CntW'(mid_q) + skt_pkg::CntW'(1);
							state_q <= skt_pkg::ST_PROBE;
						end else begin
							res_q.found         <= 1'b1;
							res_q.position      <= skt_pkg::PosW'(mid_q);
							res_q.found_class   <= rd_q.cls;
							res_q.found_hash    <= rd_q.hash;
							res_q.match_delay   <= rd_q.delay;
							res_q.secure_length <= secure;
							hit_valid_q         <= 1'b1;
							hit_id_q            <= key_q.id;
							hit_pos_q           <= mid_q;
							state_q             <= skt_pkg::ST_DONE;
						end
					end else begin
						state_q <= skt_pkg::ST_PROBE;
						// upper bound; the entry just below lo tells about a duplicate
						if (rd_q.id <= key_q.id) begin
							lo_q  <= skt_pkg::CntW'(mid_q) + skt_pkg::CntW'(1);
							dup_q <= (rd_q.id == key_q.id);
						end else begin
							hi_q <= skt_pkg::CntW'(mid_q);
						end
					end
				end
				skt_pkg::ST_SHRD: begin
					state_q <= skt_pkg::ST_SHWR;
				end
				skt_pkg::ST_SHWR: begin
					i_q     <= i_dec;
					state_q <= (i_dec > lo_q) ? skt_pkg::ST_SHRD : skt_pkg::ST_PUT;
				end
				skt_pkg::ST_PUT: begin
					count_q         <= count_q + skt_pkg::CntW'(1);
					hit_valid_q     <= 1'b0;
					res_q.position  <= skt_pkg::PosW'(lo_q);
					res_q.duplicate <= dup_q;
					state_q         <= skt_pkg::ST_DONE;
				end
				skt_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= skt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= skt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Input capture and output payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= skt_pkg::op_t'(s_tuser);
			key_q <= skt_pkg::entry_t'(s_tdata[skt_pkg::InW-1:0]);
		end
		if (state_q == skt_pkg::ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

`ifndef SYNTHESIS
	// Fill level never passes the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= skt_pkg::CntW'(skt_pkg::TableDepth))
		else $error("entry count above table depth");

	// A valid cache entry always points inside the filled part of the table
	a_hit_inside: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid_q |-> ({1'b0, hit_pos_q} < count_q))
		else $error("cached position outside table");

	// A cache-answered result is a found result
	a_hit_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.cache_hit) |-> out_q.found)
		else $error("cache hit without found");

	// Insert outcome and lookup outcome never mix
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.table_full) |-> (!out_q.found && out_q.position == '0))
		else $error("table full mixed with lookup result");

	// Only an insert grows the table, by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q) && count_q != '0) |->
		(count_q == $past(count_q) + skt_pkg::CntW'(1) && $past(state_q) == skt_pkg::ST_PUT))
		else $error("unexpected entry count change");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Scoreboard: keeps its own copy of the sorted table and the last-hit cache,
// queues the result each accepted command should produce, checks result transfers
class key_table_scoreboard;
	skt_pkg::entry_t          rows[skt_pkg::TableDepth];
	int unsigned              count;
	bit                       hit_valid;
	logic [skt_pkg::IdW-1:0]  hit_id;
	int unsigned              hit_row;
	logic [skt_pkg::LenW-1:0] min_len;
	skt_pkg::result_t         expected_results[$];
	int unsigned              errors;

	function new();
		count     = 0;
		hit_valid = 1'b0;
		hit_id    = '0;
		hit_row   = 0;
		min_len   = skt_pkg::SecureLengthReset;
		errors    = 0;
	endfunction

	// Apply one command to the table copy and return the result it gives
	function skt_pkg::result_t table_outcome(skt_pkg::op_t op, skt_pkg::entry_t cmd);
		skt_pkg::result_t res;
		int unsigned      lo, hi, mid, slot, i;
		bit               hit, cached;
		res    = '0;
		slot   = 0;
		hit    = 1'b0;
		cached = 1'b0;
		case (op)
			skt_pkg::OP_CLEAR: begin
				count     = 0;
				hit_valid = 1'b0;
			end
			skt_pkg::OP_INSERT: begin
				// first slot past every entry with id <= new id
				lo = 0;
				hi = count;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (rows[mid].id <= cmd.id)
						lo = mid + 1;
					else
						hi = mid;
				end
				res.duplicate = (lo > 0) && (rows[lo - 1].id == cmd.id);
				if (count >= skt_pkg::TableDepth) begin
					res.table_full = 1'b1;
				end else begin
					for (i = count; i > lo; i--)
						rows[i] = rows[i - 1];
					rows[lo]     = cmd;
					count++;
					hit_valid    = 1'b0;
					res.position = skt_pkg::PosW'(lo);
				end
			end
			skt_pkg::OP_LOOKUP: begin
				if (hit_valid && hit_id == cmd.id && hit_row < count) begin
					slot   = hit_row;
					hit    = 1'b1;
					cached = 1'b1;
				end else begin
					// first match probed wins when ids repeat
					lo = 0;
					hi = count;
					while (lo < hi && !hit) begin
						mid = lo + (hi - lo) / 2;
						if (cmd.id < rows[mid].id)
							hi = mid;
						else if (cmd.id > rows[mid].id)
							lo = mid + 1;
						else begin
							slot = mid;
							hit  = 1'b1;
						end
					end
					if (hit) begin
						hit_valid = 1'b1;
						hit_id    = cmd.id;
						hit_row   = slot;
					end
				end
				if (hit) begin
					res.found         = 1'b1;
					res.cache_hit     = cached;
					res.position      = skt_pkg::PosW'(slot);
					res.found_class   = rows[slot].cls;
					res.found_hash    = rows[slot].hash;
					res.match_delay   = rows[slot].delay;
					res.secure_length = rows[slot].cls || (rows[slot].len >= min_len);
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function void note_command(skt_pkg::op_t op, skt_pkg::entry_t cmd);
		expected_results.push_back(table_outcome(op, cmd));
	endfunction

	task report(string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	task check_result(skt_pkg::result_t got);
		skt_pkg::result_t want;
		if (expected_results.size() == 0) begin
			report("result transfer with no command pending");
			return;
		end
		want = expected_results.pop_front();
		check_field("found", got.found, want.found);
		check_field("cache_hit", got.cache_hit, want.cache_hit);
		check_field("position", got.position, want.position);
		check_field("found_class", got.found_class, want.found_class);
		check_field("found_hash", got.found_hash, want.found_hash);
		check_field("match_delay", got.match_delay, want.match_delay);
		check_field("secure_length", got.secure_length, want.secure_length);
		check_field("duplicate", got.duplicate, want.duplicate);
		check_field("table_full", got.table_full, want.table_full);
	endtask
endclass

module tb;
	localparam int IdleLimit = 5000;
	localparam int HoldCycles = 400;
	localparam int ItemTarget = 750;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [skt_pkg::LenW-1:0]       cfg_data  = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [skt_pkg::InBytes*8-1:0]  s_tdata   = '0;
	logic [1:0]                     s_tuser   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [skt_pkg::OutBytes*8-1:0] m_tdata;

	key_table_scoreboard     sb;
	logic [skt_pkg::IdW-1:0] known_ids[$];
	logic [skt_pkg::IdW-1:0] last_lookup_id = '0;
	int unsigned             items_sent = 0;
	int unsigned             idle_cycles = 0;
	bit                      quiet = 1'b0;
	bit                      hold_request = 1'b0;

	sorted_key_table_with_lookup_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(skt_pkg::result_t'(m_tdata[skt_pkg::OutW-1:0]));
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off on request, none at the end
	initial begin
		wait (arst_n);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_request = 1'b0;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat (quiet ? 1 : $urandom_range(1, 30)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	// One command transfer; returns at the accepting edge or after a gap
	task automatic send_command(skt_pkg::op_t op, skt_pkg::entry_t cmd);
		s_tvalid <= 1'b1;
		s_tdata  <= cmd;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		sb.note_command(op, cmd);
		if (op != skt_pkg::OP_NONE)
			items_sent++;
		// last stretch of the run goes without idling
		if (items_sent >= ItemTarget - 100)
			quiet = 1'b1;
		if (op == skt_pkg::OP_CLEAR)
			known_ids.delete();
		else if (op == skt_pkg::OP_INSERT && known_ids.size() < 80)
			known_ids.push_back(cmd.id);
		else if (op == skt_pkg::OP_LOOKUP)
			last_lookup_id = cmd.id;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (sb.expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic write_min_length(logic [skt_pkg::LenW-1:0] value);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.min_len = value;
	endtask

	// Ids: mostly a narrow range so that repeats and hits are common
	function automatic logic [skt_pkg::IdW-1:0] pick_id(bit prefer_known);
		if (prefer_known && known_ids.size() != 0 && $urandom_range(0, 4) != 0)
			return known_ids[$urandom_range(0, known_ids.size() - 1)];
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return skt_pkg::IdW'($urandom);
			default: return skt_pkg::IdW'($urandom_range(0, 48));
		endcase
	endfunction

	function automatic skt_pkg::entry_t random_entry(logic [skt_pkg::IdW-1:0] id);
		skt_pkg::entry_t e;
		int              near;
		e.id   = id;
		e.cls  = 1'($urandom_range(0, 1));
		e.hash = skt_pkg::HashW'($urandom_range(0, 31));
		// half the lengths sit within two of the secure threshold
		near = int'(sb.min_len) + $urandom_range(0, 4) - 2;
		if (near < 0)
			near = 0;
		if (near > 1023)
			near = 1023;
		e.len   = ($urandom_range(0, 1) == 0) ? skt_pkg::LenW'($urandom_range(0, 1023)) :
		          skt_pkg::LenW'(near);
		e.delay = ($urandom_range(0, 9) == 0) ? {skt_pkg::DelayW{1'b1}} :
		          skt_pkg::DelayW'($urandom);
		return e;
	endfunction

	task automatic random_lookup();
		logic [skt_pkg::IdW-1:0] id;
		id = ($urandom_range(0, 3) == 0) ? last_lookup_id : pick_id(1'b1);
		send_command(skt_pkg::OP_LOOKUP, random_entry(id));
	endtask

	task automatic mixed_command();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			random_lookup();
		else if (r < 88)
			send_command(skt_pkg::OP_INSERT, random_entry(pick_id(1'b0)));
		else if (r < 93)
			send_command(skt_pkg::OP_CLEAR, random_entry(pick_id(1'b0)));
		else if (r < 96)
			send_command(skt_pkg::OP_NONE, random_entry(pick_id(1'b0)));
		else
			send_command(skt_pkg::OP_INSERT, random_entry(pick_id(1'b1)));
	endtask

	initial begin
		int unsigned              phase;
		int unsigned              fill;
		logic [skt_pkg::LenW-1:0] setting;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extreme fields, duplicates, threshold, cache behavior
		send_command(skt_pkg::OP_LOOKUP, random_entry('0));
		send_command(skt_pkg::OP_NONE, '1);
		send_command(skt_pkg::OP_INSERT,
			skt_pkg::entry_t'{delay: '0, hash: '0, len: '0, cls: 1'b0, id: '0});
		send_command(skt_pkg::OP_INSERT,
			skt_pkg::entry_t'{delay: '1, hash: '1, len: '1, cls: 1'b1, id: '1});
		send_command(skt_pkg::OP_INSERT, skt_pkg::entry_t'{delay: 24'd1234, hash: 5'd7,
			len: 10'd10, cls: 1'b1, id: '0});
		send_command(skt_pkg::OP_INSERT, skt_pkg::entry_t'{delay: 24'd55, hash: 5'd3,
			len: 10'd10, cls: 1'b0, id: 32'd5});
		send_command(skt_pkg::OP_INSERT, skt_pkg::entry_t'{delay: 24'd66, hash: 5'd4,
			len: 10'd9, cls: 1'b0, id: 32'd6});
		send_command(skt_pkg::OP_LOOKUP, random_entry('0));
		send_command(skt_pkg::OP_LOOKUP, random_entry('0));
		send_command(skt_pkg::OP_LOOKUP, random_entry(32'd9));
		send_command(skt_pkg::OP_LOOKUP, random_entry('0));
		send_command(skt_pkg::OP_LOOKUP, random_entry('1));
		send_command(skt_pkg::OP_LOOKUP, random_entry(32'd5));
		send_command(skt_pkg::OP_LOOKUP, random_entry(32'd6));
		send_command(skt_pkg::OP_INSERT, skt_pkg::entry_t'{delay: 24'd77, hash: 5'd9,
			len: '1, cls: 1'b0, id: 32'd7});
		send_command(skt_pkg::OP_LOOKUP, random_entry(32'd6));
		send_command(skt_pkg::OP_LOOKUP, random_entry(32'd6));
		send_command(skt_pkg::OP_CLEAR, '1);
		send_command(skt_pkg::OP_LOOKUP, random_entry('0));
		send_command(skt_pkg::OP_LOOKUP, random_entry('1));

		// random phases: new setting, clear, fill, then mixed traffic
		phase = 0;
		while (items_sent < ItemTarget) begin
			case (phase % 4)
				0: setting = '0;
				1: setting = '1;
				2: setting = skt_pkg::SecureLengthReset;
				default: setting = skt_pkg::LenW'($urandom_range(0, 1023));
			endcase
			write_min_length(setting);
			send_command(skt_pkg::OP_CLEAR, random_entry(pick_id(1'b0)));
			if (phase == 1 || $urandom_range(0, 7) == 0)
				fill = $urandom_range(skt_pkg::TableDepth, skt_pkg::TableDepth + 6);
			else
				fill = $urandom_range(1, 12);
			repeat (fill)
				if (items_sent < ItemTarget)
					send_command(skt_pkg::OP_INSERT, random_entry(pick_id(1'b0)));
			// long result-side hold-off while commands keep coming
			if (phase == 2)
				hold_request = 1'b1;
			repeat ($urandom_range(20, 50))
				if (items_sent < ItemTarget)
					mixed_command();
			phase++;
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
